// ===== rtl/cdf_pkg.sv =====
// Shared types, constants and a helper function of the checked frame deframer.
package cdf_pkg;

  // Sizing of the receive buffer and of the name area.
  localparam int MAX_BUFFER = 65536;
  localparam int NAME_WORDS = 32;
  localparam int NAME_AW    = 5;

  // Frame layout constants.
  localparam logic [31:0] MIN_LEN     = 32'd271;
  localparam logic [31:0] BUF_LIM     = 32'(MAX_BUFFER - 10);
  localparam logic [15:0] NAME_FIRST  = 16'd16;
  localparam logic [15:0] NAME_LAST   = 16'd270;
  localparam logic [7:0]  NAME_K_LAST = 8'(NAME_LAST - NAME_FIRST);

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_FRAME_MARKER = 16'h0D10;
  localparam logic [15:0] RST_MAX_LEN      =
      (MAX_BUFFER - 10 > 65535) ? 16'hFFFF : 16'(MAX_BUFFER - 10);
  localparam logic [15:0] RST_OK_CODE      = 16'h00A2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FRAME_MARKER = 2'd0;
  localparam logic [1:0] CFG_MAX_LEN      = 2'd1;
  localparam logic [1:0] CFG_OK_CODE      = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_MARKER = 3'd1,
    ST_BAD_LEN    = 3'd2,
    ST_TOO_LONG   = 3'd3,
    ST_CSUM       = 3'd4
  } status_t;

  // Front end parse phase.
  typedef enum logic {
    FR_HEADER,
    FR_PAYLOAD
  } front_state_t;

  // Back end result sequencer.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_OUT
  } back_state_t;

  // One finished frame, handed from the front end to the back end.
  typedef struct packed {
    status_t     status;
    logic [15:0] code;
    logic [31:0] user;
    logic [31:0] ftype;
  } job_t;

  // Name memory write request from the front end.
  typedef struct packed {
    logic               we;
    logic [NAME_AW-1:0] addr;
    logic [63:0]        data;
  } name_wr_t;

  // True when any byte of the word is zero.
  function automatic logic has_zero_byte(input logic [63:0] w);
    logic z;
    z = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (w[8*i +: 8] == 8'd0) begin
        z = 1'b1;
      end
    end
    return z;
  endfunction

endpackage

// ===== rtl/cdf_front.sv =====
// Front end: parses the byte stream into headers and payloads and classifies frames.
module cdf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         frame_marker,
  input  logic [15:0]         max_stream_len,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  input  logic                q_full,
  output logic                q_push,
  output cdf_pkg::job_t       q_push_data,
  output cdf_pkg::name_wr_t   name_wr,
  input  logic                done_ok
);

  cdf_pkg::front_state_t phase_r, phase_nxt;
  logic [3:0]  hcnt_r;
  logic [15:0] pcnt_r;
  logic [15:0] marker_r;
  logic [31:0] exp_sum_r;
  logic [31:0] len_r;
  logic [31:0] sum_r;
  logic [15:0] code_r;
  logic [31:0] user_r;
  logic [31:0] type_r;
  logic [63:0] acc_r;
  logic        name_busy_r;

  logic              accept;
  logic              hdr_last;
  logic [31:0]       len_full;
  logic [31:0]       limit;
  cdf_pkg::status_t  hdr_status;
  logic              in_name;
  logic [7:0]        name_k;
  logic              pay_end;
  logic [31:0]       sum_nxt;
  logic [63:0]       acc_nxt;
  logic              frame_ok;

  // Header checks, evaluated on the tenth header byte.
  always_comb begin
    len_full = {len_r[23:0], in_rx_byte};
    limit    = ({16'd0, max_stream_len} < cdf_pkg::BUF_LIM) ?
               {16'd0, max_stream_len} : cdf_pkg::BUF_LIM;
    priority if (marker_r != frame_marker) begin
      hdr_status = cdf_pkg::ST_BAD_MARKER;
    end else if (len_full < cdf_pkg::MIN_LEN || len_full[31]) begin
      hdr_status = cdf_pkg::ST_BAD_LEN;
    end else if (len_full > limit) begin
      hdr_status = cdf_pkg::ST_TOO_LONG;
    end else begin
      hdr_status = cdf_pkg::ST_OK;
    end
  end

  // Payload position decode and the running checksum.
  always_comb begin
    hdr_last = (hcnt_r == 4'd9);
    in_name  = (pcnt_r >= cdf_pkg::NAME_FIRST) && (pcnt_r <= cdf_pkg::NAME_LAST);
    name_k   = 8'(pcnt_r - cdf_pkg::NAME_FIRST);
    pay_end  = (16'(pcnt_r + 16'd1) == len_r[15:0]);
    sum_nxt  = sum_r + {24'd0, in_rx_byte};
    frame_ok = (sum_nxt == exp_sum_r);
    if (name_k[2:0] == 3'd0) begin
      acc_nxt = {56'd0, in_rx_byte};
    end else begin
      acc_nxt = acc_r;
      acc_nxt[{name_k[2:0], 3'b000} +: 8] = in_rx_byte;
    end
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        cdf_pkg::FR_HEADER: begin
          if (hdr_last && hdr_status == cdf_pkg::ST_OK) begin
            phase_nxt = cdf_pkg::FR_PAYLOAD;
          end
        end
        cdf_pkg::FR_PAYLOAD: begin
          if (pay_end) begin
            phase_nxt = cdf_pkg::FR_HEADER;
          end
        end
        default: phase_nxt = cdf_pkg::FR_HEADER;
      endcase
    end
  end

  // Handshake, frame requests to the queue and name memory writes.
  always_comb begin
    in_ready    = !q_full &&
                  !(phase_r == cdf_pkg::FR_PAYLOAD && in_name && name_busy_r);
    accept      = in_valid && in_ready;
    q_push      = 1'b0;
    q_push_data = '0;
    name_wr     = '0;
    unique case (phase_r)
      cdf_pkg::FR_HEADER: begin
        if (accept && hdr_last && hdr_status != cdf_pkg::ST_OK) begin
          q_push             = 1'b1;
          q_push_data.status = hdr_status;
        end
      end
      cdf_pkg::FR_PAYLOAD: begin
        if (accept && pay_end) begin
          q_push = 1'b1;
          if (frame_ok) begin
            q_push_data.status = cdf_pkg::ST_OK;
            q_push_data.code   = code_r;
            q_push_data.user   = user_r;
            q_push_data.ftype  = type_r;
          end else begin
            q_push_data.status = cdf_pkg::ST_CSUM;
          end
        end
        // A name word is written once its last byte is in.
        if (accept && in_name && {1'b0, name_k[7:3]} < 6'(cdf_pkg::NAME_WORDS) &&
            (name_k[2:0] == 3'd7 || name_k == cdf_pkg::NAME_K_LAST)) begin
          name_wr.we   = 1'b1;
          name_wr.addr = name_k[7:3];
          name_wr.data = acc_nxt;
        end
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= cdf_pkg::FR_HEADER;
      hcnt_r      <= 4'd0;
      pcnt_r      <= 16'd0;
      name_busy_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      name_busy_r <= (name_busy_r && !done_ok) ||
                     (q_push && q_push_data.status == cdf_pkg::ST_OK);
      if (accept) begin
        if (phase_r == cdf_pkg::FR_HEADER) begin
          hcnt_r <= hdr_last ? 4'd0 : 4'(hcnt_r + 4'd1);
          pcnt_r <= 16'd0;
        end else begin
          pcnt_r <= pay_end ? 16'd0 : 16'(pcnt_r + 16'd1);
        end
      end
    end
  end

  // Header and payload field capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (phase_r == cdf_pkg::FR_HEADER) begin
        unique case (hcnt_r)
          4'd0:    marker_r[7:0]    <= in_rx_byte;
          4'd1:    marker_r[15:8]   <= in_rx_byte;
          4'd2:    exp_sum_r[7:0]   <= in_rx_byte;
          4'd3:    exp_sum_r[15:8]  <= in_rx_byte;
          4'd4:    exp_sum_r[23:16] <= in_rx_byte;
          4'd5:    exp_sum_r[31:24] <= in_rx_byte;
          default: len_r            <= len_full;
        endcase
        sum_r <= 32'd0;
      end else begin
        sum_r <= sum_nxt;
        if (pcnt_r < 16'd2) begin
          code_r[{pcnt_r[0], 3'b000} +: 8] <= in_rx_byte;
        end else if (pcnt_r >= 16'd4 && pcnt_r < 16'd8) begin
          user_r[{pcnt_r[1:0], 3'b000} +: 8] <= in_rx_byte;
        end else if (pcnt_r >= 16'd8 && pcnt_r < 16'd12) begin
          type_r[{pcnt_r[1:0], 3'b000} +: 8] <= in_rx_byte;
        end
        if (in_name) begin
          acc_r <= acc_nxt;
        end
      end
    end
  end

endmodule

// ===== rtl/cdf_queue.sv =====
// Two-entry queue of finished frames between the front end and the back end.
module cdf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cdf_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output cdf_pkg::job_t pop_data,
  output logic          empty
);

  cdf_pkg::job_t entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  // Status flags and head of the queue.
  always_comb begin
    full     = (count_r == 2'd2);
    empty    = (count_r == 2'd0);
    pop_data = entry_r[rd_ptr_r];
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   count_r <= 2'(count_r + 2'd1);
        2'b01:   count_r <= 2'(count_r - 2'd1);
        default: count_r <= count_r;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/cdf_back.sv =====
// Back end: holds the name memory and delivers the result items of each frame.
module cdf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       ok_code,
  input  cdf_pkg::name_wr_t name_wr,
  input  logic              q_empty,
  input  cdf_pkg::job_t     q_pop_data,
  output logic              q_pop,
  output logic              done_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [15:0]       out_resp_code,
  output logic              out_upload_ok,
  output logic [31:0]       out_user_id,
  output logic [31:0]       out_file_type,
  output logic [63:0]       out_name_word,
  output logic [4:0]        out_word_index,
  output logic              out_last
);

  logic [63:0] name_mem [cdf_pkg::NAME_WORDS];
  logic [cdf_pkg::NAME_WORDS-1:0] zflag_r;

  cdf_pkg::back_state_t state_r, state_nxt;
  cdf_pkg::job_t        job_r;
  logic [4:0]           idx_r;
  logic [63:0]          rd_data_r;

  logic job_ok;
  logic last;

  // Result fields; an error result carries zeros from the queue.
  always_comb begin
    job_ok         = (job_r.status == cdf_pkg::ST_OK);
    last           = !job_ok || zflag_r[idx_r] ||
                     (idx_r == 5'(cdf_pkg::NAME_WORDS - 1));
    out_status     = job_r.status;
    out_resp_code  = job_r.code;
    out_upload_ok  = job_ok && (job_r.code == ok_code);
    out_user_id    = job_r.user;
    out_file_type  = job_r.ftype;
    out_name_word  = job_ok ? rd_data_r : 64'd0;
    out_word_index = idx_r;
    out_last       = last;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cdf_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_pop_data.status == cdf_pkg::ST_OK) ?
                      cdf_pkg::BK_READ : cdf_pkg::BK_OUT;
        end
      end
      cdf_pkg::BK_READ: state_nxt = cdf_pkg::BK_OUT;
      cdf_pkg::BK_OUT: begin
        if (out_ready) begin
          state_nxt = last ? cdf_pkg::BK_IDLE : cdf_pkg::BK_READ;
        end
      end
      default: state_nxt = cdf_pkg::BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    q_pop     = (state_r == cdf_pkg::BK_IDLE) && !q_empty;
    out_valid = (state_r == cdf_pkg::BK_OUT);
    done_ok   = out_valid && out_ready && last && job_ok;
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdf_pkg::BK_IDLE;
      idx_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        idx_r <= 5'd0;
      end else if (out_valid && out_ready && !last) begin
        idx_r <= 5'(idx_r + 5'd1);
      end
    end
  end

  // Current frame descriptor.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_pop_data;
    end
  end

  // Name memory with registered read, plus a zero-byte flag per word.
  always_ff @(posedge clk) begin
    if (name_wr.we) begin
      name_mem[name_wr.addr] <= name_wr.data;
      zflag_r[name_wr.addr]  <= cdf_pkg::has_zero_byte(name_wr.data);
    end
    if (state_r == cdf_pkg::BK_READ) begin
      rd_data_r <= name_mem[idx_r];
    end
  end

endmodule

// ===== rtl/checked_frame_deframer_top.sv =====
// Top level of the checked frame deframer: configuration registers and block wiring.
//
// The deframer takes one received byte per cycle and cuts the stream into frames of a
// 2-byte marker, a 4-byte checksum, a 4-byte big-endian length and the payload. In steady
// state a byte is taken every cycle. A finished frame is placed in a two-entry queue, and
// the input stalls while that queue is full. A good frame's name area lives in a single
// 32-word memory with one read port, so once the next frame reaches its name area (payload
// byte 16) the input also stalls until the previous good frame's name words have all been
// delivered. Each result item is read from the memory (BK_READ), then held in BK_OUT until
// taken, so a good frame gives its 1 to 32 name words; an error result skips the read and
// is shown in the cycle after fetch. The user must write configuration through cfg_we,
// cfg_index and cfg_wdata only while the block is idle; the block does not enforce this.
module checked_frame_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_resp_code,
  output logic        out_upload_ok,
  output logic [31:0] out_user_id,
  output logic [31:0] out_file_type,
  output logic [63:0] out_name_word,
  output logic [4:0]  out_word_index,
  output logic        out_last
);

  logic [15:0] frame_marker_r;
  logic [15:0] max_len_r;
  logic [15:0] ok_code_r;

  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  cdf_pkg::job_t     q_push_data;
  cdf_pkg::job_t     q_pop_data;
  cdf_pkg::name_wr_t name_wr;
  logic              done_ok;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_marker_r <= cdf_pkg::RST_FRAME_MARKER;
      max_len_r      <= cdf_pkg::RST_MAX_LEN;
      ok_code_r      <= cdf_pkg::RST_OK_CODE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cdf_pkg::CFG_FRAME_MARKER: frame_marker_r <= cfg_wdata;
        cdf_pkg::CFG_MAX_LEN:      max_len_r      <= cfg_wdata;
        cdf_pkg::CFG_OK_CODE:      ok_code_r      <= cfg_wdata;
        default:                   ok_code_r      <= ok_code_r;
      endcase
    end
  end

  // Frame parser.
  cdf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .frame_marker   (frame_marker_r),
    .max_stream_len (max_len_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_push_data    (q_push_data),
    .name_wr        (name_wr),
    .done_ok        (done_ok)
  );

  // Finished frame queue.
  cdf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // Result delivery.
  cdf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .ok_code        (ok_code_r),
    .name_wr        (name_wr),
    .q_empty        (q_empty),
    .q_pop_data     (q_pop_data),
    .q_pop          (q_pop),
    .done_ok        (done_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_resp_code  (out_resp_code),
    .out_upload_ok  (out_upload_ok),
    .out_user_id    (out_user_id),
    .out_file_type  (out_file_type),
    .out_name_word  (out_name_word),
    .out_word_index (out_word_index),
    .out_last       (out_last)
  );

endmodule

// ===== rtl/cdf_checker.sv =====
// Port-level checker for the checked frame deframer, bound to the top level.
module cdf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [15:0] out_resp_code,
  input logic        out_upload_ok,
  input logic [63:0] out_name_word,
  input logic [4:0]  out_word_index,
  input logic        out_last
);

  // A stalled result keeps its name word and position.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_name_word) &&
                                $stable(out_word_index) && $stable(out_last))
    else $error("stalled result changed");

  // An error result is a single, empty item.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != cdf_pkg::ST_OK |->
      out_last && out_name_word == 64'd0 && out_word_index == 5'd0)
    else $error("error result is not a single empty item");

  // An error result never reports a successful upload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != cdf_pkg::ST_OK |-> !out_upload_ok && out_resp_code == 16'd0)
    else $error("error result carries captured fields");

  // A name word that is not the last one holds no zero byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == cdf_pkg::ST_OK && !out_last |->
      out_name_word[7:0] != 8'd0 && out_name_word[15:8] != 8'd0 &&
      out_name_word[23:16] != 8'd0 && out_name_word[31:24] != 8'd0 &&
      out_name_word[39:32] != 8'd0 && out_name_word[47:40] != 8'd0 &&
      out_name_word[55:48] != 8'd0 && out_name_word[63:56] != 8'd0)
    else $error("name run continued past a zero byte");

endmodule

bind checked_frame_deframer_top cdf_checker u_cdf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_resp_code  (out_resp_code),
  .out_upload_ok  (out_upload_ok),
  .out_name_word  (out_name_word),
  .out_word_index (out_word_index),
  .out_last       (out_last)
);
